### design/svb_pkg.sv
// shared types, codes and defaults for the 2d skinned vertex blend block
`timescale 1ns / 1ps

package svb_pkg;

  // default sizes
  localparam int unsigned MAX_BONES_DEF = 64;
  localparam int unsigned FRAC_BITS_DEF = 16;

  // words per bone in the bone store
  localparam int unsigned ELEM_COUNT = 6;

  // item function codes
  localparam logic FUNC_BONE_LOAD = 1'b0;
  localparam logic FUNC_INFLUENCE = 1'b1;

  // bone element codes
  localparam logic [2:0] ELEM_M00 = 3'd0;
  localparam logic [2:0] ELEM_M01 = 3'd1;
  localparam logic [2:0] ELEM_M10 = 3'd2;
  localparam logic [2:0] ELEM_M11 = 3'd3;
  localparam logic [2:0] ELEM_TX  = 3'd4;
  localparam logic [2:0] ELEM_TY  = 3'd5;

  // configuration register indexes
  localparam logic CFG_OFFSET_X = 1'b0;
  localparam logic CFG_OFFSET_Y = 1'b1;

  // input item
  typedef struct packed {
    logic               func;
    logic [5:0]         bone_index;
    logic [2:0]         element_select;
    logic signed [31:0] element_value;
    logic signed [31:0] local_x;
    logic signed [31:0] local_y;
    logic signed [31:0] deform_x;
    logic signed [31:0] deform_y;
    logic [16:0]        blend_weight;
    logic [15:0]        tex_u_in;
    logic [15:0]        tex_v_in;
    logic               last_influence;
  } in_t;

  // result item
  typedef struct packed {
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic [15:0]        tex_u_out;
    logic [15:0]        tex_v_out;
  } out_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_EMIT = 3'b100
  } state_e;

endpackage

### design/skinned_vertex_blend_2d.sv
// top level of the 2d linear blend skinning block
//
//  port group     | direction | handshake             | item
//  ---------------+-----------+-----------------------+---------------------------
//  in_*           | input     | in_valid_i/in_stall_o | bone load or influence
//  out_*          | output    | out_valid_o/out_stall_i | blended vertex
//  cfg_*          | input     | cfg_we_i, no wait     | skeleton offset x / y
//
//  a bone load does not stall the input; the block stays ready for the next item
//  an influence stalls the input while the sequencer runs: six bone store reads
//  through one ram port, four of them into one shared multiplier, then two
//  weight multiplies and two accumulate steps; a last influence adds an emit step
//  for the output; the output register frees the sequencer; a stalled output
//  holds the next last influence in its emit step until the register is taken
//  reset clears control state, accumulators and offsets; the bone store is
//  not cleared and must be loaded before use
`timescale 1ns / 1ps

module skinned_vertex_blend_2d #(
  parameter int unsigned MAX_BONES = svb_pkg::MAX_BONES_DEF,
  parameter int unsigned FRAC_BITS = svb_pkg::FRAC_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  svb_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output svb_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [31:0]   cfg_wdata_i
);

  import svb_pkg::*;

  localparam int unsigned Depth = MAX_BONES * ELEM_COUNT;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned ProdW = 65;
  localparam int unsigned LinW  = ProdW - FRAC_BITS + 2;
  localparam int unsigned WTermW = ProdW - 16;
  localparam int unsigned AccW  = 48;

  localparam logic signed [LinW-1:0] LinMax = LinW'(64'sd2147483647);
  localparam logic signed [LinW-1:0] LinMin = LinW'(-64'sd2147483648);
  localparam logic signed [AccW+1:0] AccMax = (AccW+2)'(64'sh7fff_ffff_ffff);
  localparam logic signed [AccW+1:0] AccMin = (AccW+2)'(-64'sh8000_0000_0000);
  localparam logic signed [AccW:0]   WldMax = (AccW+1)'(64'sd2147483647);
  localparam logic signed [AccW:0]   WldMin = (AccW+1)'(-64'sd2147483648);

  // sequencer steps within an influence
  localparam logic [2:0] STEP_M00 = 3'd0;
  localparam logic [2:0] STEP_M01 = 3'd1;
  localparam logic [2:0] STEP_M10 = 3'd2;
  localparam logic [2:0] STEP_M11 = 3'd3;
  localparam logic [2:0] STEP_TX  = 3'd4;
  localparam logic [2:0] STEP_TY  = 3'd5;
  localparam logic [2:0] STEP_WY  = 3'd6;
  localparam logic [2:0] STEP_ACY = 3'd7;

  state_e state_q, state_d;
  logic [2:0] step_q, step_d;

  logic signed [31:0] vx_q, vy_q, px_q, py_q;
  logic [16:0]        w_q;
  logic [15:0]        tex_u_q, tex_v_q;
  logic               last_q;
  logic               ok_q;
  logic [AddrW-1:0]   base_q;
  logic signed [LinW-1:0] lin_q, xsum_q;
  logic signed [AccW-1:0] sum_x_q, sum_y_q;
  logic signed [31:0] off_x_q, off_y_q;
  logic               out_valid_q;
  out_t               out_q;

  logic               in_fire, load_fire, infl_fire, emit_fire;
  logic               in_ok;
  logic [9:0]         in_base10;
  logic [AddrW-1:0]   in_base;
  logic               ram_we;
  logic [AddrW-1:0]   ram_waddr, ram_raddr;
  logic [31:0]        ram_rdata;
  logic signed [31:0] elem;
  logic signed [31:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [ProdW-1:0] prod;
  logic signed [LinW-1:0]  term, lin_add, px_sum, py_sum;
  logic signed [WTermW-1:0] wterm;
  logic signed [AccW+1:0]  acc_x_sum, acc_y_sum;
  logic signed [AccW-1:0]  acc_x_sat, acc_y_sat;
  logic signed [AccW:0]    wld_x_sum, wld_y_sum;
  logic signed [31:0]      wld_x, wld_y;
  logic signed [32:0]      vx_sum, vy_sum;
  logic signed [31:0]      vx_sat, vy_sat;

  // handshake
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign load_fire   = in_fire && (in_data_i.func == FUNC_BONE_LOAD);
  assign infl_fire   = in_fire && (in_data_i.func == FUNC_INFLUENCE);
  assign emit_fire   = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // bone address of the incoming item
  assign in_ok     = ({26'b0, in_data_i.bone_index} < MAX_BONES);
  assign in_base10 = {2'b0, in_data_i.bone_index, 2'b0} + {3'b0, in_data_i.bone_index, 1'b0};
  assign in_base   = AddrW'(in_base10);

  // bone store
  assign ram_we    = load_fire && in_ok &&
                     ({29'b0, in_data_i.element_select} < ELEM_COUNT);
  assign ram_waddr = in_base + AddrW'(in_data_i.element_select);
  assign ram_raddr = (state_q == S_IDLE) ? in_base : (base_q + AddrW'(step_q) + AddrW'(1));

  svb_ram #(
    .Width (32),
    .Depth (Depth)
  ) u_bone_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_data_i.element_value),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // bones out of range read as zero
  assign elem = ok_q ? $signed(ram_rdata) : 32'sd0;

  // deformed local position, saturated
  assign vx_sum = {in_data_i.local_x[31], in_data_i.local_x} +
                  {in_data_i.deform_x[31], in_data_i.deform_x};
  assign vy_sum = {in_data_i.local_y[31], in_data_i.local_y} +
                  {in_data_i.deform_y[31], in_data_i.deform_y};
  assign vx_sat = (vx_sum[32] == vx_sum[31]) ? vx_sum[31:0] :
                  (vx_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff);
  assign vy_sat = (vy_sum[32] == vy_sum[31]) ? vy_sum[31:0] :
                  (vy_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff);

  // multiplier operand select
  always_comb begin
    mul_a = vx_q;
    mul_b = {elem[31], elem};
    case (step_q) inside
      STEP_M00, STEP_M10: mul_a = vx_q;
      STEP_M01, STEP_M11: mul_a = vy_q;
      STEP_TY: begin
        mul_a = px_q;
        mul_b = {16'b0, w_q};
      end
      STEP_WY: begin
        mul_a = py_q;
        mul_b = {16'b0, w_q};
      end
      default: mul_a = vx_q;
    endcase
  end

  svb_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // matrix terms, floor shift by the fraction width
  assign term    = LinW'(prod >>> FRAC_BITS);
  assign lin_add = lin_q + term;
  assign px_sum  = xsum_q + LinW'(elem);
  assign py_sum  = lin_q + LinW'(elem);

  // weighted term and saturating accumulate
  assign wterm     = WTermW'(prod >>> 16);
  assign acc_x_sum = (AccW+2)'(sum_x_q) + (AccW+2)'(wterm);
  assign acc_y_sum = (AccW+2)'(sum_y_q) + (AccW+2)'(wterm);
  assign acc_x_sat = (acc_x_sum > AccMax) ? AccW'(AccMax) :
                     (acc_x_sum < AccMin) ? AccW'(AccMin) : AccW'(acc_x_sum);
  assign acc_y_sat = (acc_y_sum > AccMax) ? AccW'(AccMax) :
                     (acc_y_sum < AccMin) ? AccW'(AccMin) : AccW'(acc_y_sum);

  // world position with skeleton offset
  assign wld_x_sum = (AccW+1)'(sum_x_q) + (AccW+1)'(off_x_q);
  assign wld_y_sum = (AccW+1)'(sum_y_q) + (AccW+1)'(off_y_q);
  assign wld_x = (wld_x_sum > WldMax) ? 32'sh7fff_ffff :
                 (wld_x_sum < WldMin) ? 32'sh8000_0000 : wld_x_sum[31:0];
  assign wld_y = (wld_y_sum > WldMax) ? 32'sh7fff_ffff :
                 (wld_y_sum < WldMin) ? 32'sh8000_0000 : wld_y_sum[31:0];

  // sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      S_IDLE: begin
        step_d = STEP_M00;
        if (infl_fire) state_d = S_RUN;
      end
      S_RUN: begin
        step_d = step_q + 3'd1;
        if (step_q == STEP_ACY) state_d = last_q ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (emit_fire) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= STEP_M00;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // latch influence operands
  always_ff @(posedge clk_i) begin
    if (infl_fire) begin
      vx_q    <= vx_sat;
      vy_q    <= vy_sat;
      w_q     <= in_data_i.blend_weight;
      tex_u_q <= in_data_i.tex_u_in;
      tex_v_q <= in_data_i.tex_v_in;
      last_q  <= in_data_i.last_influence;
      ok_q    <= in_ok;
      base_q  <= in_base;
    end
  end

  // affine transform datapath
  always_ff @(posedge clk_i) begin
    if (state_q == S_RUN) begin
      case (step_q)
        STEP_M01: lin_q <= term;
        STEP_M10: lin_q <= lin_add;
        STEP_M11: begin
          xsum_q <= lin_q;
          lin_q  <= term;
        end
        STEP_TX: begin
          px_q  <= (px_sum > LinMax) ? 32'sh7fff_ffff :
                   (px_sum < LinMin) ? 32'sh8000_0000 : px_sum[31:0];
          lin_q <= lin_add;
        end
        STEP_TY: begin
          py_q <= (py_sum > LinMax) ? 32'sh7fff_ffff :
                  (py_sum < LinMin) ? 32'sh8000_0000 : py_sum[31:0];
        end
        default: ;
      endcase
    end
  end

  // accumulators and skeleton offsets
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_x_q <= '0;
      sum_y_q <= '0;
      off_x_q <= '0;
      off_y_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_OFFSET_X: off_x_q <= $signed(cfg_wdata_i);
          CFG_OFFSET_Y: off_y_q <= $signed(cfg_wdata_i);
          default: ;
        endcase
      end
      if (emit_fire) begin
        sum_x_q <= '0;
        sum_y_q <= '0;
      end else if (state_q == S_RUN && step_q == STEP_WY) begin
        sum_x_q <= acc_x_sat;
      end else if (state_q == S_RUN && step_q == STEP_ACY) begin
        sum_y_q <= acc_y_sat;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= emit_fire || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_q.world_x   <= wld_x;
      out_q.world_y   <= wld_y;
      out_q.tex_u_out <= tex_u_q;
      out_q.tex_v_out <= tex_v_q;
    end
  end

endmodule

### design/svb_ram.sv
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module svb_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 384,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### design/svb_mul.sv
// shared signed multiplier with registered product
`timescale 1ns / 1ps

module svb_mul (
  input  logic               clk_i,
  input  logic signed [31:0] a_i,
  input  logic signed [32:0] b_i,
  output logic signed [64:0] prod_o
);

  // one product per cycle, registered
  always_ff @(posedge clk_i) begin
    prod_o <= a_i * b_i;
  end

endmodule

### design/svb_checker.sv
// port level checks for the skinned vertex blend block, bound to the top level
`timescale 1ns / 1ps

module svb_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input svb_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input svb_pkg::out_t out_data_o
);

  import svb_pkg::*;

  // a bone load leaves the block ready
  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.func == FUNC_BONE_LOAD) |=> !in_stall_o)
    else $error("bone load stalled the input");

  // an influence still holds the input stalled at the last step of its sequence
  a_infl_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.func == FUNC_INFLUENCE)
    |-> ##8 in_stall_o)
    else $error("influence sequence ended early");

  // a new vertex appears only from a running influence
  a_emit_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("vertex emitted without an influence in progress");

  // a stalled vertex is held
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled vertex changed or dropped");

endmodule

bind skinned_vertex_blend_2d svb_checker u_svb_checker (.*);
